// ===== rtl/lob_pkg.sv =====
`default_nettype none
package lob_pkg;

    // default number of resting orders per side
    localparam int BOOK_DEPTH_DEF = 32;

    // result codes
    typedef enum logic [1:0] {
        KIND_ACCEPT = 2'd0,
        KIND_TRADE  = 2'd1,
        KIND_DROP   = 2'd2,
        KIND_REJECT = 2'd3
    } t_kind;

    // incoming order item
    typedef struct packed {
        logic        side;
        logic [31:0] price;
        logic [23:0] quantity;
    } t_order;

    // result item
    typedef struct packed {
        t_kind       kind;
        logic [31:0] ord_ident;
        logic [23:0] fill_quantity;
        logic [31:0] fill_price;
        logic        last;
    } t_result;

    // one resting order in the book store
    typedef struct packed {
        logic [31:0] price;
        logic [23:0] qty;
        logic [31:0] ident;
    } t_entry;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic stage_rej;
        logic stage_ack;
        logic rd_head;
        logic trade;
        logic rest_begin;
        logic shift;
        logic put_new;
        logic drop;
        logic finish;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic invalid;
        logic rem_zero;
        logic opp_empty;
        logic crosses;
        logic own_full;
        logic own_empty;
        logic ahead;
        logic idx_zero;
        logic out_free;
    } t_sts;

endpackage
`default_nettype wire

// ===== rtl/lob_ctrl.sv =====
`default_nettype none
module lob_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire lob_pkg::t_sts i_sts,
    output lob_pkg::t_cmd      o_cmd
);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b00000001,
        S_CHECK = 8'b00000010,
        S_MREQ  = 8'b00000100,
        S_MWAIT = 8'b00001000,
        S_REST  = 8'b00010000,
        S_IWAIT = 8'b00100000,
        S_IPUT  = 8'b01000000,
        S_FIN   = 8'b10000000
    } t_state;

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_sts.invalid) begin
                    o_cmd.stage_rej = 1'b1;
                    n_state         = S_FIN;
                end else begin
                    o_cmd.stage_ack = 1'b1;
                    n_state         = S_MREQ;
                end
            end
            S_MREQ: begin
                if (i_sts.rem_zero) begin
                    n_state = S_FIN;
                end else if (i_sts.opp_empty) begin
                    n_state = S_REST;
                end else begin
                    o_cmd.rd_head = 1'b1;
                    n_state       = S_MWAIT;
                end
            end
            S_MWAIT: begin
                if (!i_sts.crosses) begin
                    n_state = S_REST;
                end else if (i_sts.out_free) begin
                    o_cmd.trade = 1'b1;
                    n_state     = S_MREQ;
                end
            end
            S_REST: begin
                if (i_sts.rem_zero) begin
                    n_state = S_FIN;
                end else if (i_sts.own_full) begin
                    if (i_sts.out_free) begin
                        o_cmd.drop = 1'b1;
                        n_state    = S_FIN;
                    end
                end else begin
                    o_cmd.rest_begin = 1'b1;
                    n_state          = i_sts.own_empty ? S_IPUT : S_IWAIT;
                end
            end
            S_IWAIT: begin
                if (i_sts.ahead) begin
                    o_cmd.put_new = 1'b1;
                    n_state       = S_FIN;
                end else begin
                    o_cmd.shift = 1'b1;
                    if (i_sts.idx_zero) begin
                        n_state = S_IPUT;
                    end
                end
            end
            S_IPUT: begin
                o_cmd.put_new = 1'b1;
                n_state       = S_FIN;
            end
            S_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    a_trade_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.trade |-> i_sts.out_free)
        else $error("trade issued with output slot busy");
    a_put_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.put_new |-> !i_sts.own_full)
        else $error("insert into full side");
    a_load_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> (r_state == S_CHECK) && !o_in_ready)
        else $error("load did not move to check");
`endif

endmodule
`default_nettype wire

// ===== rtl/lob_dpath.sv =====
`default_nettype none
module lob_dpath #(
    parameter int BOOK_DEPTH = lob_pkg::BOOK_DEPTH_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire lob_pkg::t_cmd    i_cmd,
    output lob_pkg::t_sts         o_sts,
    input  wire lob_pkg::t_order  i_in_data,
    output lob_pkg::t_result      o_out_data,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready
);

    localparam int AW  = $clog2(BOOK_DEPTH);
    localparam int CW  = $clog2(BOOK_DEPTH + 1);
    localparam int MAW = $clog2(2 * BOOK_DEPTH);
    localparam logic [AW:0]    DEP_A = (AW + 1)'(BOOK_DEPTH);
    localparam logic [CW-1:0]  DEP_C = CW'(BOOK_DEPTH);
    localparam logic [MAW-1:0] DEP_M = MAW'(BOOK_DEPTH);

    // ring buffer slot to memory address, bids in the low half
    function automatic logic [MAW-1:0] f_addr(input logic sd, input logic [AW-1:0] hd,
                                              input logic [AW-1:0] li);
        logic [AW:0] sum;
        logic [AW:0] wrap;
        sum = {1'b0, hd} + {1'b0, li};
        if (sum >= DEP_A) begin
            wrap = sum - DEP_A;
        end else begin
            wrap = sum;
        end
        f_addr = sd ? (MAW'(wrap) + DEP_M) : MAW'(wrap);
    endfunction

    lob_pkg::t_entry  r_mem [0:2*BOOK_DEPTH-1];
    lob_pkg::t_entry  r_rd;
    logic             r_side;
    logic [31:0]      r_price;
    logic [23:0]      r_rem;
    logic [31:0]      r_id;
    logic [31:0]      r_next_id;
    logic [AW-1:0]    r_head [0:1];
    logic [CW-1:0]    r_cnt [0:1];
    logic [AW-1:0]    r_idx;
    logic [AW-1:0]    r_wpos;
    lob_pkg::t_result r_pend;
    logic             r_pend_v;
    lob_pkg::t_result r_out;
    logic             r_out_v;

    logic            own;
    logic            opp;
    logic [CW-1:0]   own_cnt;
    logic [CW-1:0]   opp_cnt;
    logic [CW-1:0]   own_last;
    logic [23:0]     fill;
    logic            out_free;
    logic [AW:0]     head_inc;
    logic [AW-1:0]   head_nxt;
    logic            rd_en;
    logic [MAW-1:0]  rd_addr;
    logic            wr_en;
    logic [MAW-1:0]  wr_addr;
    lob_pkg::t_entry wr_data;

    assign own      = r_side;
    assign opp      = ~r_side;
    assign own_cnt  = r_cnt[own];
    assign opp_cnt  = r_cnt[opp];
    assign own_last = own_cnt - CW'(1);
    assign fill     = (r_rd.qty < r_rem) ? r_rd.qty : r_rem;
    assign out_free = !r_out_v || i_out_ready;

    // opposite head advance after a full fill
    assign head_inc = {1'b0, r_head[opp]} + (AW + 1)'(1);
    assign head_nxt = (head_inc == DEP_A) ? '0 : head_inc[AW-1:0];

    // status toward the controller
    always_comb begin
        o_sts.invalid   = (r_price == '0) || (r_rem == '0);
        o_sts.rem_zero  = (r_rem == '0);
        o_sts.opp_empty = (opp_cnt == '0);
        o_sts.crosses   = r_side ? (r_rd.price >= r_price) : (r_rd.price <= r_price);
        o_sts.own_full  = (own_cnt == DEP_C);
        o_sts.own_empty = (own_cnt == '0);
        o_sts.ahead     = r_side ? (r_rd.price <= r_price) : (r_rd.price >= r_price);
        o_sts.idx_zero  = (r_idx == '0);
        o_sts.out_free  = out_free;
    end

    // memory port selection
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = '0;
        wr_en   = 1'b0;
        wr_addr = '0;
        wr_data = r_rd;
        if (i_cmd.rd_head) begin
            rd_en   = 1'b1;
            rd_addr = f_addr(opp, r_head[opp], '0);
        end else if (i_cmd.rest_begin) begin
            rd_en   = 1'b1;
            rd_addr = f_addr(own, r_head[own], own_last[AW-1:0]);
        end else if (i_cmd.shift) begin
            rd_en   = 1'b1;
            rd_addr = f_addr(own, r_head[own], r_idx - AW'(1));
        end
        if (i_cmd.trade && (r_rd.qty > r_rem)) begin
            wr_en       = 1'b1;
            wr_addr     = f_addr(opp, r_head[opp], '0);
            wr_data     = r_rd;
            wr_data.qty = r_rd.qty - fill;
        end else if (i_cmd.shift) begin
            wr_en   = 1'b1;
            wr_addr = f_addr(own, r_head[own], r_wpos);
            wr_data = r_rd;
        end else if (i_cmd.put_new) begin
            wr_en   = 1'b1;
            wr_addr = f_addr(own, r_head[own], r_wpos);
            wr_data = '{price: r_price, qty: r_rem, ident: r_id};
        end
    end

    // book store
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd <= r_mem[rd_addr];
        end
    end

    // order working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_side  <= i_in_data.side;
            r_price <= i_in_data.price;
            r_rem   <= i_in_data.quantity;
        end else if (i_cmd.trade) begin
            r_rem <= r_rem - fill;
        end
        if (i_cmd.stage_ack) begin
            r_id <= r_next_id;
        end
        if (i_cmd.rest_begin) begin
            r_idx  <= own_last[AW-1:0];
            r_wpos <= own_cnt[AW-1:0];
        end else if (i_cmd.shift) begin
            r_idx  <= r_idx - AW'(1);
            r_wpos <= r_idx;
        end
    end

    // book bookkeeping and id counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next_id <= 32'd1;
            r_head[0] <= '0;
            r_head[1] <= '0;
            r_cnt[0]  <= '0;
            r_cnt[1]  <= '0;
        end else begin
            if (i_cmd.stage_ack) begin
                r_next_id <= r_next_id + 32'd1;
            end
            if (i_cmd.trade && (r_rd.qty <= r_rem)) begin
                r_head[opp] <= head_nxt;
                r_cnt[opp]  <= opp_cnt - CW'(1);
            end
            if (i_cmd.put_new) begin
                r_cnt[own] <= own_cnt + CW'(1);
            end
        end
    end

    // staged result and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            if (i_cmd.stage_rej || i_cmd.stage_ack) begin
                r_pend_v <= 1'b1;
            end else if (i_cmd.finish) begin
                r_pend_v <= 1'b0;
            end
            if (i_cmd.trade || i_cmd.drop || i_cmd.finish) begin
                r_out_v <= 1'b1;
            end else if (i_out_ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.stage_rej) begin
            r_pend <= '{kind: lob_pkg::KIND_REJECT, ord_ident: '0, fill_quantity: '0,
                        fill_price: '0, last: 1'b0};
        end else if (i_cmd.stage_ack) begin
            r_pend <= '{kind: lob_pkg::KIND_ACCEPT, ord_ident: r_next_id,
                        fill_quantity: r_rem, fill_price: r_price, last: 1'b0};
        end else if (i_cmd.trade) begin
            r_pend <= '{kind: lob_pkg::KIND_TRADE, ord_ident: r_id, fill_quantity: fill,
                        fill_price: r_rd.price, last: 1'b0};
        end else if (i_cmd.drop) begin
            r_pend <= '{kind: lob_pkg::KIND_DROP, ord_ident: r_id, fill_quantity: r_rem,
                        fill_price: r_price, last: 1'b0};
        end
        // staged item moves out, marked last only on finish
        if (i_cmd.trade || i_cmd.drop || i_cmd.finish) begin
            r_out <= '{kind: r_pend.kind, ord_ident: r_pend.ord_ident,
                       fill_quantity: r_pend.fill_quantity, fill_price: r_pend.fill_price,
                       last: i_cmd.finish};
        end
    end

    assign o_out_data  = r_out;
    assign o_out_valid = r_out_v;

`ifndef NO_ASSERTIONS
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt[0] <= DEP_C) && (r_cnt[1] <= DEP_C))
        else $error("side count beyond depth");
    a_trade_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.trade |=> (r_rem < $past(r_rem)))
        else $error("trade did not reduce remainder");
    a_finish_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |=> (r_out_v && r_out.last && !r_pend_v))
        else $error("finish did not present final item");
`endif

endmodule
`default_nettype wire

// ===== rtl/limit_order_book_matcher.sv =====
// limit order book matcher for one symbol
// input channel (i_in_valid / o_in_ready / i_in_data): one new limit order per item,
// side, price in cents and quantity
// output channel (o_out_valid / i_out_ready / o_out_data): result items, an accept
// or reject first, then trades, then possibly a dropped remainder; last marks the
// final item of an order
// one order is worked at a time: the order is taken in and checked, each trade reads
// the opposite head and then updates the opposite side, matching ends when nothing
// remains, the opposite side is empty or its head does not cross, then insertion
// reads the last resting order and shifts each one it moves past, and the final
// item is handed over
// the book memory has a single read port and a single write port
// the output register holds a finished item while the next order is taken in;
// a stalled receiver holds the work at the next result until it drains
// reset empties both sides and restarts order ids at 1; no clearing pass
`default_nettype none
module limit_order_book_matcher #(
    parameter int BOOK_DEPTH = lob_pkg::BOOK_DEPTH_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire lob_pkg::t_order  i_in_data,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output lob_pkg::t_result      o_out_data
);

    lob_pkg::t_cmd cmd;
    lob_pkg::t_sts sts;

    // sequencer
    lob_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // book store and order datapath
    lob_dpath #(
        .BOOK_DEPTH (BOOK_DEPTH)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_in_data   (i_in_data),
        .o_out_data  (o_out_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready)
    );

endmodule
`default_nettype wire
